// ===== hw/rtl/dga_pkg.sv =====
// ----------------------------------------------------------------------------
// dga_pkg
// Shared types for the daily group averager: controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package dga_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_FLUSH,
        ST_DIV,
        ST_PUSH
    } state_t;

    typedef struct packed {
        logic capture;     // latch the accepted input item
        logic load_close;  // close the open run, start a new one with the item
        logic accumulate;  // add the item to the open run or open a run
        logic load_final;  // close the run for the final flush
        logic div_step;    // one quotient bit
        logic push;        // move the finished result to the output register
    } cmd_t;

    typedef struct packed {
        logic close_hit;   // item day differs from the open run's day
        logic item_final;  // latched item is the last of the stream
        logic flush_pend;  // a final flush still follows the current result
        logic div_last;    // divider is on its last step
        logic out_free;    // output register can take a result this cycle
    } status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dga_ctrl.sv =====
// ----------------------------------------------------------------------------
// dga_ctrl
// Controller: sequences capture, run update, division and result transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module dga_ctrl
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire dga_pkg::status_t status,
    output dga_pkg::cmd_t         cmd
);

    dga_pkg::state_t state_reg;
    dga_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dga_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dga_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = dga_pkg::ST_EVAL;
                end
            end
            dga_pkg::ST_EVAL:
            begin
                if (status.close_hit)
                begin
                    state_next = dga_pkg::ST_DIV;
                end
                else if (status.item_final)
                begin
                    state_next = dga_pkg::ST_FLUSH;
                end
                else
                begin
                    state_next = dga_pkg::ST_IDLE;
                end
            end
            dga_pkg::ST_FLUSH:
            begin
                state_next = dga_pkg::ST_DIV;
            end
            dga_pkg::ST_DIV:
            begin
                if (status.div_last)
                begin
                    state_next = dga_pkg::ST_PUSH;
                end
            end
            dga_pkg::ST_PUSH:
            begin
                if (status.out_free)
                begin
                    state_next = status.flush_pend ? dga_pkg::ST_FLUSH : dga_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dga_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            dga_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            dga_pkg::ST_EVAL:
            begin
                cmd.load_close = status.close_hit;
                cmd.accumulate = !status.close_hit;
            end
            dga_pkg::ST_FLUSH:
            begin
                cmd.load_final = 1'b1;
            end
            dga_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            dga_pkg::ST_PUSH:
            begin
                cmd.push = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/dga_datapath.sv =====
// ----------------------------------------------------------------------------
// dga_datapath
// Run accumulator, date tracking, restoring divider and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dga_datapath
#(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 16,
    parameter int DATA_W      = 40
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire dga_pkg::cmd_t           cmd,
    output dga_pkg::status_t             status,
    input  wire logic [DATA_W-1:0]       in_data,
    input  wire logic                    in_last,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [DATA_W-1:0]            out_data,
    output logic                         out_last
);

    localparam int SUM_BITS = SAMPLE_BITS + COUNT_BITS;
    localparam int CNT_W    = $clog2(SUM_BITS);
    localparam int DAY_LO   = SAMPLE_BITS;
    localparam int MON_LO   = SAMPLE_BITS + 5;
    localparam int YEAR_LO  = SAMPLE_BITS + 9;

    // latched input item
    logic signed [SAMPLE_BITS-1:0] item_sample_reg;
    logic [4:0]                    item_day_reg;
    logic [3:0]                    item_month_reg;
    logic [11:0]                   item_year_reg;
    logic                          item_final_reg;

    // run state
    logic signed [SUM_BITS-1:0]    run_sum_reg;
    logic [COUNT_BITS-1:0]         run_count_reg;
    logic [4:0]                    prev_day_reg;
    logic [3:0]                    prev_month_reg;
    logic [11:0]                   prev_year_reg;
    logic                          run_open_reg;
    logic                          flush_pend_reg;

    // divider
    logic [SUM_BITS-1:0]           dvd_reg;
    logic [COUNT_BITS-1:0]         rem_reg;
    logic [COUNT_BITS-1:0]         dvs_reg;
    logic                          neg_reg;
    logic [CNT_W-1:0]              div_cnt_reg;

    // result date held during division
    logic [4:0]                    res_day_reg;
    logic [3:0]                    res_month_reg;
    logic [11:0]                   res_year_reg;
    logic                          res_end_reg;

    // output register
    logic                          out_valid_reg;
    logic [SAMPLE_BITS-1:0]        out_avg_reg;
    logic [4:0]                    out_day_reg;
    logic [3:0]                    out_month_reg;
    logic [11:0]                   out_year_reg;
    logic                          out_last_reg;

    logic signed [SUM_BITS-1:0]    sample_ext;
    logic [SUM_BITS-1:0]           sum_mag;
    logic [COUNT_BITS:0]           rem_shift;
    logic [COUNT_BITS:0]           rem_diff;
    logic                          rem_ge;
    logic [SAMPLE_BITS-1:0]        quot_lo;
    logic [SAMPLE_BITS-1:0]        avg_next;
    logic                          count_full;
    logic                          load_div;

    assign sample_ext = SUM_BITS'(item_sample_reg);
    assign sum_mag    = run_sum_reg[SUM_BITS-1] ? SUM_BITS'(-run_sum_reg)
                                                : SUM_BITS'(run_sum_reg);
    assign rem_shift  = {rem_reg, dvd_reg[SUM_BITS-1]};
    assign rem_diff   = rem_shift - {1'b0, dvs_reg};
    assign rem_ge     = rem_shift >= {1'b0, dvs_reg};
    assign quot_lo    = dvd_reg[SAMPLE_BITS-1:0];
    assign avg_next   = neg_reg ? SAMPLE_BITS'(-quot_lo) : quot_lo;
    assign count_full = &run_count_reg;
    assign load_div   = cmd.load_close || cmd.load_final;

    assign status.close_hit  = run_open_reg && (item_day_reg != prev_day_reg);
    assign status.item_final = item_final_reg;
    assign status.flush_pend = flush_pend_reg;
    assign status.div_last   = div_cnt_reg == '0;
    assign status.out_free   = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_sample_reg <= in_data[SAMPLE_BITS-1:0];
            item_day_reg    <= in_data[DAY_LO +: 5];
            item_month_reg  <= in_data[MON_LO +: 4];
            item_year_reg   <= in_data[YEAR_LO +: 12];
            item_final_reg  <= in_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_sum_reg    <= '0;
            run_count_reg  <= '0;
            prev_day_reg   <= '0;
            prev_month_reg <= '0;
            prev_year_reg  <= '0;
            run_open_reg   <= 1'b0;
            flush_pend_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_close || (cmd.accumulate && !run_open_reg))
            begin
                run_sum_reg   <= sample_ext;
                run_count_reg <= COUNT_BITS'(1);
                run_open_reg  <= 1'b1;
            end
            else if (cmd.accumulate && !count_full)
            begin
                run_sum_reg   <= run_sum_reg + sample_ext;
                run_count_reg <= run_count_reg + COUNT_BITS'(1);
            end
            else if (cmd.load_final)
            begin
                run_sum_reg   <= '0;
                run_count_reg <= '0;
                run_open_reg  <= 1'b0;
            end

            if (cmd.load_close || cmd.accumulate)
            begin
                prev_day_reg   <= item_day_reg;
                prev_month_reg <= item_month_reg;
                prev_year_reg  <= item_year_reg;
            end

            if (cmd.load_close)
            begin
                flush_pend_reg <= item_final_reg;
            end
            else if (cmd.load_final)
            begin
                flush_pend_reg <= 1'b0;
            end
        end
    end

    // restoring division of the sum magnitude by the count, one bit a cycle
    always_ff @(posedge clk)
    begin
        if (load_div)
        begin
            dvd_reg       <= sum_mag;
            rem_reg       <= '0;
            dvs_reg       <= run_count_reg;
            neg_reg       <= run_sum_reg[SUM_BITS-1];
            div_cnt_reg   <= CNT_W'(SUM_BITS - 1);
            res_day_reg   <= prev_day_reg;
            res_month_reg <= prev_month_reg;
            res_year_reg  <= prev_year_reg;
            res_end_reg   <= cmd.load_final || !item_final_reg;
        end
        else if (cmd.div_step)
        begin
            dvd_reg     <= {dvd_reg[SUM_BITS-2:0], rem_ge};
            rem_reg     <= rem_ge ? rem_diff[COUNT_BITS-1:0] : rem_shift[COUNT_BITS-1:0];
            div_cnt_reg <= div_cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            out_avg_reg   <= avg_next;
            out_day_reg   <= res_day_reg;
            out_month_reg <= res_month_reg;
            out_year_reg  <= res_year_reg;
            out_last_reg  <= res_end_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = DATA_W'({out_year_reg, out_month_reg, out_day_reg, out_avg_reg});
    assign out_last  = out_last_reg;

    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> (!out_valid_reg || out_ready))
        else $error("result pushed over a pending transfer");

    a_close_open: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_close |-> run_open_reg)
        else $error("run closed while none was open");

    a_open_count: assert property (@(posedge clk) disable iff (!rst_n)
        run_open_reg |-> (run_count_reg != '0))
        else $error("open run with zero count");

    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_final |=> (!run_open_reg && !flush_pend_reg))
        else $error("final flush left a run open");

endmodule

`default_nettype wire

// ===== hw/rtl/daily_group_averager_core.sv =====
// ----------------------------------------------------------------------------
// daily_group_averager_core
// Averages runs of consecutive samples sharing a day number; emits the
// truncated mean with the run's date when the day changes or on tlast.
// ----------------------------------------------------------------------------
// A result passes through EVAL (and FLUSH for a final run), the bit-serial
// divider (one quotient bit per cycle) and PUSH into the output register.
// s_axis_tready is high only in idle, so no new sample is taken while a result
// is computed or waits for the output register to free.
// Reset (rst_n low, asynchronous) clears the open run, its count and its date.
`default_nettype none

module daily_group_averager_core
#(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 16
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_axis_tvalid,
    output logic      s_axis_tready,
    // sample, day_of_month[5], month_number[4], year_number[12], zero pad
    input  wire logic [((SAMPLE_BITS + 21 + 7) / 8) * 8 - 1:0] s_axis_tdata,
    input  wire logic s_axis_tlast,   // final_sample
    output logic      m_axis_tvalid,
    input  wire logic m_axis_tready,
    // average, avg_day[5], avg_month[4], avg_year[12], zero pad
    output logic [((SAMPLE_BITS + 21 + 7) / 8) * 8 - 1:0] m_axis_tdata,
    output logic      m_axis_tlast    // run_end
);

    localparam int DATA_W = ((SAMPLE_BITS + 21 + 7) / 8) * 8;

    dga_pkg::cmd_t    cmd;
    dga_pkg::status_t status;

    dga_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    dga_datapath
    #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS),
        .DATA_W      (DATA_W)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire
